// ===== hw/rtl/gsa_pkg.sv =====
`default_nettype none

package gsa_pkg;

  localparam int unsigned OP_W  = 2;
  localparam int unsigned IDX_W = 8;
  localparam int unsigned GEN_W = 32;
  localparam int unsigned ST_W  = 2;

  localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_CHECK  = 2'd2;

  localparam logic [ST_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [ST_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [ST_W-1:0] STATUS_STALE = 2'd2;

endpackage

`default_nettype wire

// ===== hw/rtl/gsa_slot_ram.sv =====
`default_nettype none

module gsa_slot_ram #(
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned DATA_W = 42
) (
  input  wire                      clk_i,
  input  wire                      en_i,
  input  wire                      we_i,
  input  wire [$clog2(DEPTH)-1:0]  addr_i,
  input  wire [DATA_W-1:0]         wdata_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem[addr_i];
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/generational_slot_allocator.sv =====
// Reply: a command taken with start is answered from registers loaded in
// the execute state. res_strobe_o is high for one cycle and the receiver
// cannot stall it. Busy blocks new commands during the read-modify-write of the
// slot memory (read at accept, write back in the following cycle).
// Reset: asynchronous, active low; empties the free list and zeroes the
// high-water mark. The slot memory needs no clearing pass.
`default_nettype none

module generational_slot_allocator import gsa_pkg::*; #(
  parameter int unsigned SLOT_COUNT = 256
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               start,
  output logic              busy,
  input  wire [OP_W-1:0]    operation_i,
  input  wire [IDX_W-1:0]   slot_index_i,
  input  wire [GEN_W-1:0]   generation_i,
  output logic              res_strobe_o,
  output logic [ST_W-1:0]   status_o,
  output logic [IDX_W-1:0]  slot_index_res_o,
  output logic [GEN_W-1:0]  generation_res_o,
  output logic              valid_res_o
);

  localparam int unsigned AW     = $clog2(SLOT_COUNT);
  localparam int unsigned LW     = AW + 1;
  localparam int unsigned CMPW   = (LW > IDX_W) ? LW : IDX_W + 1;
  localparam int unsigned DATA_W = 1 + GEN_W + LW;
  localparam logic [LW-1:0] EMPTY = LW'(SLOT_COUNT);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic              state_q, state_d;
  logic [LW-1:0]     head_q, head_d;
  logic [LW-1:0]     used_q, used_d;
  logic [OP_W-1:0]   op_q;
  logic [IDX_W-1:0]  idx_q;
  logic [GEN_W-1:0]  gen_q;
  logic              strobe_q;
  logic [ST_W-1:0]   status_q, status_d;
  logic [IDX_W-1:0]  res_idx_q, res_idx_d;
  logic [GEN_W-1:0]  res_gen_q, res_gen_d;
  logic              res_vld_q, res_vld_d;

  logic              accept;
  logic              ram_en, ram_we;
  logic [AW-1:0]     ram_addr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;
  logic              rd_active;
  logic [GEN_W-1:0]  rd_gen;
  logic [LW-1:0]     rd_link, link_clamped;
  logic [CMPW-1:0]   in_idx_ext, q_idx_ext;
  logic              handle_ok;

  assign busy   = (state_q == S_EXEC);
  assign accept = start && !busy;

  assign in_idx_ext = CMPW'(slot_index_i);
  assign q_idx_ext  = CMPW'(idx_q);

  assign {rd_active, rd_gen, rd_link} = ram_rdata;
  assign link_clamped = (rd_link > EMPTY) ? EMPTY : rd_link;
  assign handle_ok = (q_idx_ext < CMPW'(used_q)) && rd_active && (rd_gen == gen_q);

  gsa_slot_ram #(
    .DEPTH  (SLOT_COUNT),
    .DATA_W (DATA_W)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    used_d    = used_q;
    status_d  = STATUS_STALE;
    res_idx_d = idx_q;
    res_gen_d = gen_q;
    res_vld_d = 1'b0;
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = head_q[AW-1:0];
    ram_wdata = {1'b1, rd_gen, rd_link};
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          ram_en  = 1'b1;
          state_d = S_EXEC;
          if (operation_i != OP_ALLOC) begin
            ram_addr = in_idx_ext[AW-1:0];
          end
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
        case (op_q)
          OP_ALLOC: begin
            if (head_q < EMPTY) begin
              ram_en    = 1'b1;
              ram_we    = 1'b1;
              ram_addr  = head_q[AW-1:0];
              ram_wdata = {1'b1, rd_gen, rd_link};
              head_d    = link_clamped;
              status_d  = STATUS_OK;
              res_idx_d = IDX_W'(head_q);
              res_gen_d = rd_gen;
            end else if (used_q < EMPTY) begin
              ram_en    = 1'b1;
              ram_we    = 1'b1;
              ram_addr  = used_q[AW-1:0];
              ram_wdata = {1'b1, {GEN_W{1'b0}}, EMPTY};
              used_d    = used_q + LW'(1);
              status_d  = STATUS_OK;
              res_idx_d = IDX_W'(used_q);
              res_gen_d = '0;
            end else begin
              status_d  = STATUS_FULL;
              res_idx_d = '0;
              res_gen_d = '0;
            end
          end
          OP_REMOVE: begin
            res_vld_d = handle_ok;
            if (handle_ok) begin
              ram_en    = 1'b1;
              ram_we    = 1'b1;
              ram_addr  = q_idx_ext[AW-1:0];
              ram_wdata = {1'b0, rd_gen + GEN_W'(1), head_q};
              head_d    = LW'(q_idx_ext);
              status_d  = STATUS_OK;
            end
          end
          default: begin
            res_vld_d = handle_ok;
            status_d  = handle_ok ? STATUS_OK : STATUS_STALE;
          end
        endcase
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      head_q   <= EMPTY;
      used_q   <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      used_q   <= used_d;
      strobe_q <= (state_q == S_EXEC);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= operation_i;
      idx_q <= slot_index_i;
      gen_q <= generation_i;
    end
    if (state_q == S_EXEC) begin
      status_q  <= status_d;
      res_idx_q <= res_idx_d;
      res_gen_q <= res_gen_d;
      res_vld_q <= res_vld_d;
    end
  end

  assign res_strobe_o     = strobe_q;
  assign status_o         = status_q;
  assign slot_index_res_o = res_idx_q;
  assign generation_res_o = res_gen_q;
  assign valid_res_o      = res_vld_q;

endmodule

`default_nettype wire

// ===== bench/gsa_reply_checker.sv =====
`timescale 1ns / 100ps

module gsa_reply_checker import gsa_pkg::*; (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              start_i,
  input  wire              busy_i,
  input  wire [OP_W-1:0]   operation_i,
  input  wire [IDX_W-1:0]  slot_index_i,
  input  wire [GEN_W-1:0]  generation_i,
  input  wire              res_strobe_i,
  input  wire [ST_W-1:0]   status_i,
  input  wire [IDX_W-1:0]  slot_index_res_i,
  input  wire [GEN_W-1:0]  generation_res_i,
  input  wire              valid_res_i,
  output int               fail_count_o
);

  localparam int unsigned SLOT_COUNT   = 256;
  localparam logic [8:0]  LIST_EMPTY   = 9'(SLOT_COUNT);
  localparam int          REPORT_LIMIT = 10;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [IDX_W-1:0] slot;
    logic [GEN_W-1:0] gen;
    logic             valid;
  } alloc_reply_t;

  logic             slot_live [SLOT_COUNT];
  logic [GEN_W-1:0] slot_gen  [SLOT_COUNT];
  logic [8:0]       slot_link [SLOT_COUNT];
  logic [8:0]       head_free;
  logic [8:0]       high_water;
  alloc_reply_t     expected_replies [$];
  int               mismatches;

  function automatic logic handle_is_live(input logic [IDX_W-1:0] idx,
                                          input logic [GEN_W-1:0] gen);
    return (9'(idx) < high_water) && (slot_gen[idx] == gen) && slot_live[idx];
  endfunction

  // Updates the shadow pool and returns the reply for one command beat.
  function automatic alloc_reply_t predict_reply(input logic [OP_W-1:0]  op,
                                                 input logic [IDX_W-1:0] idx,
                                                 input logic [GEN_W-1:0] gen);
    alloc_reply_t r;
    logic [8:0]   pick;
    r.status = STATUS_OK;
    r.slot   = idx;
    r.gen    = gen;
    r.valid  = 1'b0;
    if (op == OP_ALLOC) begin
      if (head_free < LIST_EMPTY) begin
        pick      = head_free;
        head_free = (slot_link[pick[7:0]] > LIST_EMPTY) ? LIST_EMPTY : slot_link[pick[7:0]];
      end else if (high_water < LIST_EMPTY) begin
        pick       = high_water;
        high_water = high_water + 9'd1;
      end else begin
        pick = LIST_EMPTY;
      end
      if (pick < LIST_EMPTY) begin
        slot_live[pick[7:0]] = 1'b1;
        r.slot = pick[7:0];
        r.gen  = slot_gen[pick[7:0]];
      end else begin
        r.status = STATUS_FULL;
        r.slot   = '0;
        r.gen    = '0;
      end
    end else if (op == OP_REMOVE) begin
      r.valid = handle_is_live(idx, gen);
      if (r.valid) begin
        slot_live[idx] = 1'b0;
        slot_gen[idx]  = gen + 1'b1;
        slot_link[idx] = head_free;
        head_free      = 9'(idx);
      end else begin
        r.status = STATUS_STALE;
      end
    end else begin
      // code three behaves as check
      r.valid  = handle_is_live(idx, gen);
      r.status = r.valid ? STATUS_OK : STATUS_STALE;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    alloc_reply_t want;
    alloc_reply_t got;
    if (!rst_ni) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_live[i] = 1'b0;
        slot_gen[i]  = '0;
        slot_link[i] = LIST_EMPTY;
      end
      head_free  = LIST_EMPTY;
      high_water = '0;
      expected_replies.delete();
      mismatches = 0;
    end else begin
      if (res_strobe_i) begin
        got = {status_i, slot_index_res_i, generation_res_i, valid_res_i};
        if (expected_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: unexpected reply status %0d slot %0d gen %h valid %0d",
                     $time, got.status, got.slot, got.gen, got.valid);
        end else begin
          want = expected_replies.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $write("%0t: reply mismatch exp status %0d slot %0d gen %h valid %0d,",
                     $time, want.status, want.slot, want.gen, want.valid);
              $display(" got status %0d slot %0d gen %h valid %0d",
                       got.status, got.slot, got.gen, got.valid);
            end
          end
        end
      end
      if (start_i && !busy_i)
        expected_replies.insert(expected_replies.size(),
                                predict_reply(operation_i, slot_index_i, generation_i));
    end
    fail_count_o <= mismatches + expected_replies.size();
  end

endmodule

// ===== bench/tb_generational_slot_allocator.sv =====
`timescale 1ns / 100ps

module tb_generational_slot_allocator;
  import gsa_pkg::*;

  localparam logic [OP_W-1:0] OP_CHECK_ALT = 2'd3;
  localparam int              ITEM_COUNT   = 1430;
  localparam int              DEAD_KEEP    = 64;

  typedef struct {
    logic [IDX_W-1:0] slot;
    logic [GEN_W-1:0] gen;
  } slot_handle_t;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              start     = 1'b0;
  logic [OP_W-1:0]   cmd_op    = '0;
  logic [IDX_W-1:0]  cmd_slot  = '0;
  logic [GEN_W-1:0]  cmd_gen   = '0;
  logic              busy;
  logic              res_strobe;
  logic [ST_W-1:0]   res_status;
  logic [IDX_W-1:0]  res_slot;
  logic [GEN_W-1:0]  res_gen;
  logic              res_valid;
  int                fail_count;

  slot_handle_t      live_handles [$];
  slot_handle_t      dead_handles [$];
  logic [OP_W-1:0]   ops_in_flight [$];
  bit                no_idle = 1'b0;

  always #5 clk = ~clk;

  generational_slot_allocator DUT (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .start            (start),
    .busy             (busy),
    .operation_i      (cmd_op),
    .slot_index_i     (cmd_slot),
    .generation_i     (cmd_gen),
    .res_strobe_o     (res_strobe),
    .status_o         (res_status),
    .slot_index_res_o (res_slot),
    .generation_res_o (res_gen),
    .valid_res_o      (res_valid)
  );

  gsa_reply_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .start_i          (start),
    .busy_i           (busy),
    .operation_i      (cmd_op),
    .slot_index_i     (cmd_slot),
    .generation_i     (cmd_gen),
    .res_strobe_i     (res_strobe),
    .status_i         (res_status),
    .slot_index_res_i (res_slot),
    .generation_res_i (res_gen),
    .valid_res_i      (res_valid),
    .fail_count_o     (fail_count)
  );

  // granted handles feed the remove/check stimulus
  always @(posedge clk) begin : learn_handles
    logic [OP_W-1:0] op_seen;
    slot_handle_t    h;
    if (res_strobe && ops_in_flight.size() != 0) begin
      op_seen = ops_in_flight.pop_front();
      if (op_seen == OP_ALLOC && res_status == STATUS_OK) begin
        h.slot = res_slot;
        h.gen  = res_gen;
        live_handles.insert(live_handles.size(), h);
      end
    end
  end

  task automatic issue(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                       input logic [GEN_W-1:0] gen);
    if (!no_idle && $urandom_range(99) < 24) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    start    <= 1'b1;
    cmd_op   <= op;
    cmd_slot <= idx;
    cmd_gen  <= gen;
    if (op == OP_REMOVE) begin
      for (int i = live_handles.size() - 1; i >= 0; i--) begin
        if (live_handles[i].slot == idx && live_handles[i].gen == gen) begin
          dead_handles.insert(dead_handles.size(), live_handles[i]);
          live_handles.delete(i);
        end
      end
      if (dead_handles.size() > DEAD_KEEP) void'(dead_handles.pop_front());
    end
    @(posedge clk);
    while (busy) @(posedge clk);
    ops_in_flight.insert(ops_in_flight.size(), op);
  endtask

  task automatic random_command(input int alloc_pct);
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] idx;
    logic [GEN_W-1:0] gen;
    slot_handle_t     h;
    int               pick;
    idx = IDX_W'($urandom);
    gen = $urandom;
    if ($urandom_range(99) < alloc_pct) begin
      op = OP_ALLOC;
    end else begin
      if ($urandom_range(99) < 55) op = OP_REMOVE;
      else op = ($urandom_range(7) == 0) ? OP_CHECK_ALT : OP_CHECK;
      pick = $urandom_range(9);
      if (pick < 7 && live_handles.size() > 0) begin
        h   = live_handles[$urandom_range(live_handles.size() - 1)];
        idx = h.slot;
        gen = h.gen;
      end else if (pick == 7 && dead_handles.size() > 0) begin
        h   = dead_handles[$urandom_range(dead_handles.size() - 1)];
        idx = h.slot;
        gen = h.gen;
      end else if (pick == 8 && live_handles.size() > 0) begin
        h   = live_handles[$urandom_range(live_handles.size() - 1)];
        idx = h.slot;
        gen = $urandom_range(1) ? h.gen + 1'b1 : h.gen - 1'b1;
      end
    end
    issue(op, idx, gen);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    issue(OP_CHECK, 0, 0);
    issue(OP_REMOVE, 0, 0);
    issue(OP_ALLOC, '1, '1);
    issue(OP_CHECK, 0, 0);
    issue(OP_CHECK_ALT, 0, 0);
    issue(OP_CHECK, 0, 1);
    issue(OP_REMOVE, 0, '1);
    issue(OP_ALLOC, 0, 0);
    issue(OP_ALLOC, 0, 0);
    issue(OP_CHECK, '1, '1);
    issue(OP_REMOVE, 1, 0);
    issue(OP_CHECK, 1, 1);
    issue(OP_REMOVE, 1, 0);
    issue(OP_REMOVE, 0, 0);
    issue(OP_ALLOC, 0, 0);
    issue(OP_ALLOC, 0, 0);
    issue(OP_ALLOC, 0, 0);
    issue(OP_CHECK, 0, 1);
    issue(OP_CHECK_ALT, 3, 0);
    issue(OP_REMOVE, 2, 0);
    issue(OP_REMOVE, 3, 0);
    issue(OP_ALLOC, '1, 0);
    issue(OP_CHECK, 3, 1);

    // mixed traffic, fill past full, drain, then balanced traffic
    for (int n = 0; n < ITEM_COUNT; n++) begin
      no_idle = (n >= 1000 && n < 1200);
      if (n < 350) random_command(40);
      else if (n < 700) random_command(80);
      else if (n < 1000) random_command(15);
      else random_command(50);
    end
    start <= 1'b0;

    while (ops_in_flight.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/gsa_pkg.sv
hw/rtl/gsa_slot_ram.sv
hw/rtl/generational_slot_allocator.sv
bench/gsa_reply_checker.sv
bench/tb_generational_slot_allocator.sv
